// File: hdl/morse_keyer_command_decoder_assert.svh
// assertion macros for the morse keyer command decoder
`ifndef MORSE_KEYER_COMMAND_DECODER_ASSERT_SVH
`define MORSE_KEYER_COMMAND_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MKD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MKD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MKD_ASSERT(lbl, clk, rstn, prop, msg)
`define MKD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/mkd_pkg.sv
// shared types, codes and tables of the morse keyer command decoder
`default_nettype none
package mkd_pkg;

  localparam logic [2:0] ACT_SYMBOL = 3'd0;
  localparam logic [2:0] ACT_PAUSE  = 3'd1;
  localparam logic [2:0] ACT_TONE   = 3'd2;
  localparam logic [2:0] ACT_SPEED  = 3'd3;
  localparam logic [2:0] ACT_RISE   = 3'd4;
  localparam logic [2:0] ACT_REPLY  = 3'd5;

  localparam int unsigned DIV_DIVIDEND = 62500;
  localparam int unsigned QW = 13;

  // one queued result; div_req asks the back end to divide 62500 by value
  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  bits;
    logic [2:0]  len;
    logic [12:0] value;
    logic        last;
    logic        div_req;
  } res_t;

  function automatic logic [12:0] old_tone(input logic [3:0] p);
    logic [12:0] r;
    begin
      case (p)
        4'd1: r = 13'd4000;
        4'd2: r = 13'd2000;
        4'd3: r = 13'd1333;
        4'd4: r = 13'd1000;
        4'd5: r = 13'd800;
        4'd6: r = 13'd666;
        4'd7: r = 13'd571;
        4'd8: r = 13'd500;
        4'd9: r = 13'd444;
        4'd10: r = 13'd400;
        default: r = 13'd0;
      endcase
      return r;
    end
  endfunction

  // {len, bits} for character index c - 0x20
  function automatic logic [9:0] glyph(input logic [5:0] i);
    logic [9:0] r;
    begin
      case (i)
        6'd2:  r = {3'd6, 7'b0010010};
        6'd4:  r = {3'd7, 7'b1001000};
        6'd7:  r = {3'd6, 7'b0011110};
        6'd8:  r = {3'd5, 7'b0001101};
        6'd9:  r = {3'd6, 7'b0101101};
        6'd11: r = {3'd5, 7'b0001010};
        6'd12: r = {3'd6, 7'b0110011};
        6'd13: r = {3'd6, 7'b0100001};
        6'd14: r = {3'd6, 7'b0101010};
        6'd15: r = {3'd5, 7'b0010110};
        6'd16: r = {3'd5, 7'b0011111};
        6'd17: r = {3'd5, 7'b0011110};
        6'd18: r = {3'd5, 7'b0011100};
        6'd19: r = {3'd5, 7'b0011000};
        6'd20: r = {3'd5, 7'b0010000};
        6'd21: r = {3'd5, 7'b0000000};
        6'd22: r = {3'd5, 7'b0000001};
        6'd23: r = {3'd5, 7'b0000011};
        6'd24: r = {3'd5, 7'b0000111};
        6'd25: r = {3'd5, 7'b0001111};
        6'd26: r = {3'd5, 7'b0001101};
        6'd27: r = {3'd4, 7'b0001010};
        6'd28: r = {3'd5, 7'b0001010};
        6'd29: r = {3'd5, 7'b0010001};
        6'd30: r = {3'd6, 7'b0101000};
        6'd31: r = {3'd6, 7'b0001100};
        6'd32: r = {3'd6, 7'b0010110};
        6'd33: r = {3'd2, 7'b0000010};
        6'd34: r = {3'd4, 7'b0000001};
        6'd35: r = {3'd4, 7'b0000101};
        6'd36: r = {3'd3, 7'b0000001};
        6'd37: r = {3'd1, 7'b0000000};
        6'd38: r = {3'd4, 7'b0000100};
        6'd39: r = {3'd3, 7'b0000011};
        6'd40: r = {3'd4, 7'b0000000};
        6'd41: r = {3'd2, 7'b0000000};
        6'd42: r = {3'd4, 7'b0001110};
        6'd43: r = {3'd3, 7'b0000101};
        6'd44: r = {3'd4, 7'b0000010};
        6'd45: r = {3'd2, 7'b0000011};
        6'd46: r = {3'd2, 7'b0000001};
        6'd47: r = {3'd3, 7'b0000111};
        6'd48: r = {3'd4, 7'b0000110};
        6'd49: r = {3'd4, 7'b0001011};
        6'd50: r = {3'd3, 7'b0000010};
        6'd51: r = {3'd3, 7'b0000000};
        6'd52: r = {3'd1, 7'b0000001};
        6'd53: r = {3'd3, 7'b0000100};
        6'd54: r = {3'd4, 7'b0001000};
        6'd55: r = {3'd3, 7'b0000110};
        6'd56: r = {3'd4, 7'b0001001};
        6'd57: r = {3'd4, 7'b0001101};
        6'd58: r = {3'd4, 7'b0001100};
        6'd59: r = {3'd5, 7'b0000010};
        6'd60: r = {3'd5, 7'b0001001};
        6'd61: r = {3'd5, 7'b0001101};
        default: r = 10'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/mkd_front.sv
// front end: parses host bytes and pushes up to two results into the queue
`default_nettype none
module mkd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      byte_i,
  input  wire logic            end_i,
  output logic                 push_o,
  output mkd_pkg::res_t        push_data_o,
  input  wire logic            q_room_i
);
  localparam logic [2:0] M_IDLE = 3'd0, M_TONE = 3'd1, M_SPEED = 3'd2, M_ADMIN = 3'd3,
                         M_ECHO = 3'd4, M_RISE = 3'd5, M_FREQ = 3'd6, M_DISCARD = 3'd7;

  logic [2:0] mode_q, mode_d;
  logic [1:0] ver_q, ver_d;
  logic [6:0] spd_q, spd_d;
  logic       pend_q;          // second result of admin code 2 still to push
  logic       pend_d;

  mkd_pkg::res_t r0, r1;
  logic          n0, n1;       // result present

  function automatic mkd_pkg::res_t mk(input logic [2:0] a, input logic [12:0] v);
    mkd_pkg::res_t r;
    begin
      r = '0;
      r.action = a;
      r.value = v;
      return r;
    end
  endfunction

  always_comb begin
    logic [7:0] b, u;
    logic [9:0] g;
    logic       idle_path;
    b = byte_i;
    mode_d = mode_q;
    ver_d = ver_q;
    spd_d = spd_q;
    n0 = 1'b0;
    n1 = 1'b0;
    r0 = '0;
    r1 = '0;
    idle_path = 1'b0;
    case (mode_q)
      M_IDLE: idle_path = 1'b1;
      M_TONE: begin
        mode_d = M_IDLE;
        if (ver_q < 2'd3 && b >= 8'd1 && b <= 8'd10) begin
          n0 = 1'b1;
          r0 = mk(mkd_pkg::ACT_TONE, mkd_pkg::old_tone(b[3:0]));
        end else if (ver_q == 2'd3 && b >= 8'd15 && b <= 8'd125) begin
          n0 = 1'b1;
          r0 = mk(mkd_pkg::ACT_TONE, {5'd0, b});
          r0.div_req = 1'b1;
        end
      end
      M_SPEED: begin
        mode_d = M_IDLE;
        if (b >= 8'd5 && b <= 8'd99) begin
          spd_d = b[6:0];
          n0 = 1'b1;
          r0 = mk(mkd_pkg::ACT_SPEED, {5'd0, b});
        end else begin
          idle_path = 1'b1;
        end
      end
      M_ADMIN: begin
        mode_d = M_DISCARD;
        case (b)
          8'd2: begin
            n0 = 1'b1; n1 = 1'b1;
            r0 = mk(mkd_pkg::ACT_REPLY, 13'd31);
            r1 = mk(mkd_pkg::ACT_REPLY, 13'd3);
            ver_d = 2'd1;
          end
          8'd4: mode_d = M_ECHO;
          8'd5, 8'd6, 8'd7: begin n0 = 1'b1; r0 = mk(mkd_pkg::ACT_REPLY, 13'd0); end
          8'd9: begin n0 = 1'b1; r0 = mk(mkd_pkg::ACT_REPLY, 13'd31); end
          8'd10: ver_d = 2'd1;
          8'd11: ver_d = 2'd2;
          8'd20: ver_d = 2'd3;
          8'd21: begin n0 = 1'b1; r0 = mk(mkd_pkg::ACT_REPLY, 13'd52); end
          8'd23: begin n0 = 1'b1; r0 = mk(mkd_pkg::ACT_REPLY, 13'd3); end
          8'd24: begin n0 = 1'b1; r0 = mk(mkd_pkg::ACT_REPLY, 13'd1); end
          8'd26: mode_d = M_RISE;
          8'd27: mode_d = M_FREQ;
          default: ;
        endcase
      end
      M_ECHO: begin
        mode_d = M_DISCARD;
        n0 = 1'b1;
        r0 = mk(mkd_pkg::ACT_REPLY, {5'd0, b});
      end
      M_RISE: begin
        mode_d = M_DISCARD;
        if (b >= 8'd1 && b <= 8'd50) begin
          n0 = 1'b1;
          r0 = mk(mkd_pkg::ACT_RISE, {5'd0, b});
        end
      end
      M_FREQ: begin
        mode_d = M_DISCARD;
        n0 = 1'b1;
        r0 = mk(mkd_pkg::ACT_TONE, ({5'd0, b} << 3) + ({5'd0, b} << 1));
      end
      default: ;
    endcase
    if (idle_path) begin
      u = (b inside {[8'h61:8'h7A]}) ? b - 8'h20 : b;
      g = mkd_pkg::glyph(6'(u - 8'h20));
      if (u == 8'h20) begin
        n0 = 1'b1;
        r0 = mk(mkd_pkg::ACT_PAUSE, 13'd0);
      end else if (u > 8'h20 && u <= 8'h5D) begin
        n0 = 1'b1;
        r0 = mk(mkd_pkg::ACT_SYMBOL, 13'd0);
        r0.len = g[9:7];
        r0.bits = g[6:0];
      end else begin
        case (u)
          8'h00: mode_d = M_ADMIN;
          8'h01: mode_d = M_TONE;
          8'h02: mode_d = M_SPEED;
          8'h07: begin
            n0 = 1'b1;
            r0 = mk(mkd_pkg::ACT_REPLY, {5'd0, 2'b10, spd_q[5:0]});
            mode_d = M_DISCARD;
          end
          8'h0E: ver_d = 2'd3;
          8'h15: begin
            n0 = 1'b1;
            r0 = mk(mkd_pkg::ACT_REPLY, 13'hC0);
            mode_d = M_DISCARD;
          end
          default: ;
        endcase
      end
    end
    if (end_i) mode_d = M_IDLE;
    r0.last = ~n1;
    r1.last = 1'b1;
  end

  // a byte is taken once its first result fits; after admin code 2, only once its second is pushed
  assign in_ready_o = ~pend_q & q_room_i;
  wire take = in_valid_i & in_ready_o;
  assign push_o = pend_q ? q_room_i : (take & n0);
  assign pend_d = pend_q ? ~q_room_i : (take & n1);

  mkd_pkg::res_t hold_q;
  assign push_data_o = pend_q ? hold_q : r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      ver_q <= 2'd1;
      spd_q <= 7'd20;
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (take) begin
        mode_q <= mode_d;
        ver_q <= ver_d;
        spd_q <= spd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) hold_q <= r1;
  end
endmodule
`default_nettype wire

// File: hdl/mkd_queue.sv
// short result queue between front end and back end
`default_nettype none
module mkd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  mkd_pkg::res_t      push_data_i,
  output logic               room_o,
  output logic               valid_o,
  output mkd_pkg::res_t      data_o,
  input  wire logic          pop_i
);
  mkd_pkg::res_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign room_o  = cnt_q < 3'd4;
  assign valid_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end
endmodule
`default_nettype wire

// File: hdl/mkd_back.sv
// back end: runs the tone divider and holds the output word
`default_nettype none
module mkd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  mkd_pkg::res_t      q_data_i,
  output logic               pop_o,
  output logic               m_valid_o,
  output mkd_pkg::res_t      m_data_o,
  input  wire logic          m_ready_i
);
  localparam logic [16:0] DIVIDEND = 17'(mkd_pkg::DIV_DIVIDEND);

  logic        busy_q;
  logic [4:0]  step_q;
  logic [16:0] quo_q;
  logic [7:0]  rem_q;
  logic [7:0]  den_q;
  logic        ovalid_q;
  mkd_pkg::res_t out_q;

  wire out_free = ~ovalid_q | m_ready_i;
  // a word is taken only once the output register is free, divider words too
  assign pop_o = q_valid_i & ~busy_q & out_free;
  assign m_valid_o = ovalid_q;
  assign m_data_o = out_q;

  // restoring division, one quotient bit a cycle over 17 steps
  wire [8:0] trial = {rem_q, quo_q[16]} - {1'b0, den_q};
  wire       done = busy_q && step_q == 5'd17;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (out_free) ovalid_q <= 1'b0;
      if (busy_q) begin
        if (done) begin
          if (out_free) begin
            busy_q <= 1'b0;
            ovalid_q <= 1'b1;
          end
        end else begin
          step_q <= step_q + 5'd1;
        end
      end else if (pop_o) begin
        if (q_data_i.div_req) begin
          busy_q <= 1'b1;
          step_q <= '0;
        end else begin
          ovalid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !done) begin
      if (!trial[8]) begin
        rem_q <= trial[7:0];
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= {rem_q[6:0], quo_q[16]};
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end else if (done) begin
      out_q.value <= quo_q[12:0];
    end else if (pop_o) begin
      out_q <= q_data_i;
      den_q <= q_data_i.value[7:0];
      quo_q <= DIVIDEND;
      rem_q <= '0;
    end
  end
endmodule
`default_nettype wire

// File: hdl/morse_keyer_command_decoder.sv
// path: byte -> queue -> output register; a version 3 tone also through the divider
// throughput: one byte a cycle while the queue has room and no admin code 2 reply is
// pending; the divider holds the back end as the front fills the four-word queue
// reset: asynchronous, active low; parser idle, version 1, speed 20 wpm
`default_nettype none
`include "morse_keyer_command_decoder_assert.svh"
module morse_keyer_command_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic [7:0]  s_axis_tdata,   // byte_in
  input  wire logic        s_axis_tlast,   // message_end
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // action, pattern_bits, pattern_length, value, pad
  output logic             m_axis_tlast    // last_result
);
  logic          push, room, qv, pop;
  mkd_pkg::res_t pdata, qdata, odata;

  mkd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .byte_i(s_axis_tdata), .end_i(s_axis_tlast),
    .push_o(push), .push_data_o(pdata), .q_room_i(room)
  );

  mkd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(pdata), .room_o(room),
    .valid_o(qv), .data_o(qdata), .pop_i(pop)
  );

  mkd_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_data_i(qdata), .pop_o(pop),
    .m_valid_o(m_axis_tvalid), .m_data_o(odata), .m_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, odata.value, odata.len, odata.bits, odata.action};
  assign m_axis_tlast = odata.last;

  `MKD_ASSERT(a_no_push_full, clk_i, rst_ni, push |-> room, "push into full queue")
  `MKD_ASSERT(a_hold_out, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
  `MKD_ASSERT(a_pop_valid, clk_i, rst_ni, pop |-> qv, "pop from empty queue")
endmodule
`default_nettype wire
